[hdl/pcc_pkg.sv]
// shared types and constants for the png chunk crc checker
// no dependencies

package pcc_pkg;

  localparam int DATA_LEN_W = 31;

  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

  // chunk kinds
  localparam logic [2:0] KIND_IHDR  = 3'd0;
  localparam logic [2:0] KIND_PLTE  = 3'd1;
  localparam logic [2:0] KIND_IDAT  = 3'd2;
  localparam logic [2:0] KIND_IEND  = 3'd3;
  localparam logic [2:0] KIND_BKGD  = 3'd4;
  localparam logic [2:0] KIND_CHRM  = 3'd5;
  localparam logic [2:0] KIND_OTHER = 3'd6;

  // chunk type codes, first byte most significant
  localparam logic [31:0] TYPE_IHDR = 32'h4948_4452;
  localparam logic [31:0] TYPE_PLTE = 32'h504C_5445;
  localparam logic [31:0] TYPE_IDAT = 32'h4944_4154;
  localparam logic [31:0] TYPE_IEND = 32'h4945_4E44;
  localparam logic [31:0] TYPE_BKGD = 32'h624B_4744;
  localparam logic [31:0] TYPE_CHRM = 32'h6348_524D;

  localparam int HEADER_LEN = 13;
  localparam int CHRM_LEN   = 32;
  localparam int HDR_IDX_W  = 4;

  typedef struct packed {
    logic [2:0]  chunk_kind;
    logic        crc_ok;
    logic        length_ok;
    logic [31:0] image_width;
    logic [31:0] image_height;
    logic [7:0]  sample_depth;
    logic [7:0]  color_code;
    logic [7:0]  compression_kind;
    logic [7:0]  filter_kind;
    logic [7:0]  interlace_kind;
    logic [2:0]  channel_count;
  } result_t;

endpackage

[hdl/pcc_out_buffer.sv]
// two-entry result buffer between the chunk logic and the output channel
// depends on pcc_pkg for result_t

module pcc_out_buffer
  import pcc_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  result_t push_data,
  output logic    full,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t head
);

  logic [1:0] count;
  result_t    slot0;
  result_t    slot1;
  logic       pop;

  assign pop       = (count != 2'd0) && out_ready;
  assign out_valid = (count != 2'd0);
  assign full      = (count == 2'd2);
  assign head      = slot0;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else if (push && !pop) begin
      count <= count + 2'd1;
    end else if (pop && !push) begin
      count <= count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push && pop) begin
      if (count == 2'd1) begin
        slot0 <= push_data;
      end else begin
        slot0 <= slot1;
        slot1 <= push_data;
      end
    end else if (pop) begin
      slot0 <= slot1;
    end else if (push) begin
      if (count == 2'd0) begin
        slot0 <= push_data;
      end else begin
        slot1 <= push_data;
      end
    end
  end

endmodule

[hdl/png_chunk_crc_checker_unit.sv]
// png chunk checker top level: crc-32, type decode, length rules, ihdr fields
// depends on pcc_pkg and pcc_out_buffer
//
//   channel  signals                                   direction  moves
//   in       in_valid in_ready data_byte first_byte    into block one chunk byte
//            data_length
//   out      out_valid out_ready chunk_kind crc_ok     out of     one result per
//            length_ok image_width ... channel_count              finished chunk
//
// one byte per cycle unless stalled: the byte-wise crc update, position compares
// and header capture all settle between the state registers and the result buffer
// a result is ready in the cycle after the transfer of the last stored crc byte
// rst is synchronous and active high; it closes any open chunk and empties
// the result buffer
// a two-entry result buffer keeps in_ready high while one result waits;
// in_ready drops only while two results wait

module png_chunk_crc_checker_unit
  import pcc_pkg::*;
#(
  parameter int LENGTH_BITS = 31
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [7:0]            data_byte,
  input  logic                  first_byte,
  input  logic [DATA_LEN_W-1:0] data_length,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [2:0]            chunk_kind,
  output logic                  crc_ok,
  output logic                  length_ok,
  output logic [31:0]           image_width,
  output logic [31:0]           image_height,
  output logic [7:0]            sample_depth,
  output logic [7:0]            color_code,
  output logic [7:0]            compression_kind,
  output logic [7:0]            filter_kind,
  output logic [7:0]            interlace_kind,
  output logic [2:0]            channel_count
);

  // position counter is one bit wider than the length so length + 7 fits
  localparam int POS_W = LENGTH_BITS + 1;

  // one reflected crc-32 byte step, eight shift-and-xor stages
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  function automatic logic [2:0] kind_of(input logic [31:0] t);
    logic [2:0] k;
    case (t)
      TYPE_IHDR: k = KIND_IHDR;
      TYPE_PLTE: k = KIND_PLTE;
      TYPE_IDAT: k = KIND_IDAT;
      TYPE_IEND: k = KIND_IEND;
      TYPE_BKGD: k = KIND_BKGD;
      TYPE_CHRM: k = KIND_CHRM;
      default:   k = KIND_OTHER;
    endcase
    return k;
  endfunction

  function automatic logic [2:0] channels_of(input logic [7:0] ct);
    logic [2:0] n;
    case (ct)
      8'd0:    n = 3'd1;
      8'd2:    n = 3'd3;
      8'd3:    n = 3'd1;
      8'd4:    n = 3'd2;
      8'd6:    n = 3'd4;
      default: n = 3'd0;
    endcase
    return n;
  endfunction

  // divisible by 3: every base-4 digit has weight 1 mod 3, so sum digits per byte,
  // then the four byte sums, then fold the small sum once more
  function automatic logic div_by_3(input logic [31:0] v);
    logic [3:0] bsum [4];
    logic [5:0] s;
    logic [3:0] t;
    for (int i = 0; i < 4; i++) begin
      bsum[i] = 4'(v[8*i +: 2]) + 4'(v[8*i+2 +: 2]) + 4'(v[8*i+4 +: 2]) + 4'(v[8*i+6 +: 2]);
    end
    s = (6'(bsum[0]) + 6'(bsum[1])) + (6'(bsum[2]) + 6'(bsum[3]));
    t = 4'(s[1:0]) + 4'(s[3:2]) + 4'(s[5:4]);
    return (t == 4'd0) || (t == 4'd3) || (t == 4'd6) || (t == 4'd9);
  endfunction

  // chunk state
  logic             chunk_open;
  logic [POS_W-1:0] pos;
  logic [POS_W-1:0] data_end;     // length + 4: first crc byte position
  logic [POS_W-1:0] last_pos;     // length + 7: last crc byte position
  logic [31:0]      crc;
  logic [31:0]      type_word;
  logic [31:0]      rcv_crc;
  logic [7:0]       header [HEADER_LEN];

  // length rule flags, worked out when the length is sampled
  logic len_is13;
  logic len_is0;
  logic len_is1or6;
  logic len_is32;
  logic len_div3;

  logic                   in_fire;
  logic                   active;
  logic                   done;
  logic                   push;
  logic                   buf_full;
  logic [LENGTH_BITS-1:0] len_in;
  logic [31:0]            len_ext;
  logic [POS_W-1:0]       base_pos;
  logic [POS_W-1:0]       base_end;
  logic [31:0]            base_crc;
  logic [31:0]            base_type;
  logic [31:0]            base_rcv;
  logic                   in_type;
  logic                   in_data;
  logic                   hdr_write;
  logic [HDR_IDX_W-1:0]   hdr_idx;
  logic [POS_W-1:0]       pos_next;
  logic [31:0]            crc_next;
  logic [31:0]            type_next;
  logic [31:0]            rcv_next;
  logic [2:0]             kind;
  logic                   hdr_ok;
  result_t                res;
  result_t                head;

  assign in_ready = !buf_full;
  assign in_fire  = in_valid && in_ready;

  // bytes with no chunk open and no start mark are dropped
  assign active = first_byte || chunk_open;

  assign len_in  = data_length[LENGTH_BITS-1:0];
  assign len_ext = 32'(len_in);

  // a start mark restarts everything from this byte
  assign base_pos  = first_byte ? '0 : pos;
  assign base_end  = first_byte ? (POS_W'(len_in) + POS_W'(4)) : data_end;
  assign base_crc  = first_byte ? CRC_INIT : crc;
  assign base_type = first_byte ? 32'd0 : type_word;
  assign base_rcv  = first_byte ? 32'd0 : rcv_crc;

  // byte class: type, data, or stored crc
  assign in_type = (base_pos < POS_W'(4));
  assign in_data = !in_type && (base_pos < base_end);

  // first 13 data bytes land in the header store
  assign hdr_write = in_data && (base_pos < POS_W'(HEADER_LEN + 4));
  assign hdr_idx   = HDR_IDX_W'(base_pos - POS_W'(4));

  assign pos_next  = base_pos + POS_W'(1);
  assign crc_next  = (in_type || in_data) ? crc_byte(base_crc, data_byte) : base_crc;
  assign type_next = in_type ? {base_type[23:0], data_byte} : base_type;
  assign rcv_next  = (!in_type && !in_data) ? {base_rcv[23:0], data_byte} : base_rcv;

  // last stored crc byte closes the chunk
  assign done = chunk_open && !first_byte && (pos == last_pos);
  assign push = in_fire && done;

  always_ff @(posedge clk) begin
    if (rst) begin
      chunk_open <= 1'b0;
      pos        <= '0;
      crc        <= CRC_INIT;
      type_word  <= 32'd0;
      rcv_crc    <= 32'd0;
    end else if (in_fire && active) begin
      chunk_open <= !done;
      pos        <= pos_next;
      crc        <= crc_next;
      type_word  <= type_next;
      rcv_crc    <= rcv_next;
    end
  end

  // length sampled with the start mark
  always_ff @(posedge clk) begin
    if (in_fire && first_byte) begin
      data_end   <= POS_W'(len_in) + POS_W'(4);
      last_pos   <= POS_W'(len_in) + POS_W'(7);
      len_is13   <= (len_ext == 32'(HEADER_LEN));
      len_is0    <= (len_ext == 32'd0);
      len_is1or6 <= (len_ext == 32'd1) || (len_ext == 32'd6);
      len_is32   <= (len_ext == 32'(CHRM_LEN));
      len_div3   <= div_by_3(len_ext);
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && active && hdr_write) begin
      header[hdr_idx] <= data_byte;
    end
  end

  // result of the chunk closing on this transfer; the type word and the
  // crc are complete since the closing byte is a stored crc byte
  assign kind   = kind_of(type_word);
  assign hdr_ok = (kind == KIND_IHDR) && len_is13;

  always_comb begin
    res            = '0;
    res.chunk_kind = kind;
    res.crc_ok     = ((~crc) == rcv_next);
    case (kind)
      KIND_IHDR: res.length_ok = len_is13;
      KIND_PLTE: res.length_ok = len_div3;
      KIND_IDAT: res.length_ok = !len_is0;
      KIND_IEND: res.length_ok = len_is0;
      KIND_BKGD: res.length_ok = len_is1or6;
      KIND_CHRM: res.length_ok = len_is32;
      default:   res.length_ok = 1'b1;
    endcase
    if (hdr_ok) begin
      res.image_width      = {header[0], header[1], header[2], header[3]};
      res.image_height     = {header[4], header[5], header[6], header[7]};
      res.sample_depth     = header[8];
      res.color_code       = header[9];
      res.compression_kind = header[10];
      res.filter_kind      = header[11];
      res.interlace_kind   = header[12];
      res.channel_count    = channels_of(header[9]);
    end
  end

  pcc_out_buffer u_out_buffer (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (res),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .head      (head)
  );

  assign chunk_kind       = head.chunk_kind;
  assign crc_ok           = head.crc_ok;
  assign length_ok        = head.length_ok;
  assign image_width      = head.image_width;
  assign image_height     = head.image_height;
  assign sample_depth     = head.sample_depth;
  assign color_code       = head.color_code;
  assign compression_kind = head.compression_kind;
  assign filter_kind      = head.filter_kind;
  assign interlace_kind   = head.interlace_kind;
  assign channel_count    = head.channel_count;

  // stray bytes outside a chunk never make a result
  a_no_stray_result: assert property (@(posedge clk) disable iff (rst)
    (in_fire && !chunk_open && !first_byte) |-> !push)
    else $error("result from a byte outside any chunk");

  // a result closes the chunk
  a_close_on_result: assert property (@(posedge clk) disable iff (rst)
    push |=> !chunk_open)
    else $error("chunk still open after its result");

  // input stalls only while results are waiting
  a_stall_has_result: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("input stalled with no result waiting");

  // header fields stay zero outside ihdr
  a_hdr_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (chunk_kind != KIND_IHDR)) |->
      (image_width == 32'd0) && (image_height == 32'd0) && (channel_count == 3'd0))
    else $error("header fields set for a non-ihdr chunk");

endmodule

[bench/png_chunk_crc_checker_unit_test.sv]
// self-checking bench for png_chunk_crc_checker_unit: streams png chunks and checks results
// depends on pcc_pkg and the png_chunk_crc_checker_unit rtl

module png_chunk_crc_checker_unit_test;
  import pcc_pkg::*;

  // png color type codes, used to steer ihdr stimulus and to predict channel_count
  localparam logic [7:0] COLOR_GRAY       = 8'd0;
  localparam logic [7:0] COLOR_RGB        = 8'd2;
  localparam logic [7:0] COLOR_PALETTE    = 8'd3;
  localparam logic [7:0] COLOR_GRAY_ALPHA = 8'd4;
  localparam logic [7:0] COLOR_RGBA       = 8'd6;

  localparam int BYTE_TARGET   = 1750;
  localparam int CYCLE_LIMIT   = 500000;
  localparam int DRAIN_CYCLES  = 10;

  typedef struct {
    logic [7:0]            value;
    logic                  start;
    logic [DATA_LEN_W-1:0] length;
  } chunk_byte_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  // input side, known from time zero
  logic                  in_valid    = 1'b0;
  logic                  in_ready;
  logic [7:0]            data_byte   = 8'h00;
  logic                  first_byte  = 1'b0;
  logic [DATA_LEN_W-1:0] data_length = '0;

  // result side
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  chunk_kind;
  logic        crc_ok;
  logic        length_ok;
  logic [31:0] image_width;
  logic [31:0] image_height;
  logic [7:0]  sample_depth;
  logic [7:0]  color_code;
  logic [7:0]  compression_kind;
  logic [7:0]  filter_kind;
  logic [7:0]  interlace_kind;
  logic [2:0]  channel_count;

  png_chunk_crc_checker_unit #(
    .LENGTH_BITS(DATA_LEN_W)
  ) dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .data_byte        (data_byte),
    .first_byte       (first_byte),
    .data_length      (data_length),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .chunk_kind       (chunk_kind),
    .crc_ok           (crc_ok),
    .length_ok        (length_ok),
    .image_width      (image_width),
    .image_height     (image_height),
    .sample_depth     (sample_depth),
    .color_code       (color_code),
    .compression_kind (compression_kind),
    .filter_kind      (filter_kind),
    .interlace_kind   (interlace_kind),
    .channel_count    (channel_count)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // stream of bytes waiting to be driven, and the chunk reports still owed by the block
  chunk_byte_t pending_bytes[$];
  result_t     expected_reports[$];
  logic [7:0]  chunk_body[$];

  int unsigned planned_bytes  = 0;
  int unsigned total_bytes    = 0;
  int unsigned accepted_bytes = 0;
  int unsigned mismatches     = 0;
  int unsigned cycle_count    = 0;
  int unsigned send_gap       = 0;
  int unsigned recv_gap       = 0;
  bit          calm_in        = 1'b0;
  bit          calm_out       = 1'b0;

  // stimulus side view: is a chunk still open in the block (bytes with no start would count)
  bit stream_open = 1'b0;

  // shadow of the checker state
  logic [31:0]           cur_pos   = '0;
  logic [DATA_LEN_W-1:0] cur_len   = '0;
  logic [31:0]           run_crc   = CRC_INIT;
  logic [31:0]           cur_type  = '0;
  logic [31:0]           got_crc   = '0;
  logic [7:0]            hdr_mem[HEADER_LEN];
  bit                    in_chunk  = 1'b0;

  // ---------------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------------

  // reflected crc-32, one byte, lsb first
  function automatic logic [31:0] crc32_step(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'h0, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) c = (c >> 1) ^ CRC_POLY;
      else      c = c >> 1;
    end
    return c;
  endfunction

  function automatic logic [2:0] kind_for_type(input logic [31:0] t);
    case (t)
      TYPE_IHDR: return KIND_IHDR;
      TYPE_PLTE: return KIND_PLTE;
      TYPE_IDAT: return KIND_IDAT;
      TYPE_IEND: return KIND_IEND;
      TYPE_BKGD: return KIND_BKGD;
      TYPE_CHRM: return KIND_CHRM;
      default:   return KIND_OTHER;
    endcase
  endfunction

  function automatic logic length_allowed(input logic [2:0] k, input logic [DATA_LEN_W-1:0] len);
    case (k)
      KIND_IHDR: return len == HEADER_LEN;
      KIND_PLTE: return (len % 3) == 0;
      KIND_IDAT: return len != 0;
      KIND_IEND: return len == 0;
      KIND_BKGD: return len == 1 || len == 6;
      KIND_CHRM: return len == CHRM_LEN;
      default:   return 1'b1;
    endcase
  endfunction

  function automatic logic [2:0] channels_for(input logic [7:0] ct);
    case (ct)
      COLOR_GRAY, COLOR_PALETTE: return 3'd1;
      COLOR_GRAY_ALPHA:          return 3'd2;
      COLOR_RGB:                 return 3'd3;
      COLOR_RGBA:                return 3'd4;
      default:                   return 3'd0;
    endcase
  endfunction

  // advance the shadow state by one transferred byte; queue a report when the chunk closes
  task automatic track_byte(input logic [7:0] b, input logic start,
                            input logic [DATA_LEN_W-1:0] len);
    longint unsigned p;
    longint unsigned l;
    result_t         r;
    logic [2:0]      k;
    if (start) begin
      // a start abandons whatever chunk was open
      cur_len  = len;
      cur_pos  = '0;
      run_crc  = CRC_INIT;
      cur_type = '0;
      got_crc  = '0;
      in_chunk = 1'b1;
    end
    if (!in_chunk) return;
    p = cur_pos;
    l = cur_len;
    if (p < 4) begin
      cur_type = {cur_type[23:0], b};
      run_crc  = crc32_step(run_crc, b);
    end else if (p < l + 4) begin
      if (p - 4 < HEADER_LEN) hdr_mem[int'(p - 4)] = b;
      run_crc = crc32_step(run_crc, b);
    end else begin
      got_crc = {got_crc[23:0], b};
    end
    cur_pos = cur_pos + 32'd1;
    if (p == l + 7) begin
      in_chunk    = 1'b0;
      k           = kind_for_type(cur_type);
      r           = '0;
      r.chunk_kind = k;
      r.crc_ok     = (run_crc ^ CRC_INIT) == got_crc;
      r.length_ok  = length_allowed(k, cur_len);
      // header fields only for an ihdr of exactly the header length
      if (k == KIND_IHDR && cur_len == HEADER_LEN) begin
        r.image_width      = {hdr_mem[0], hdr_mem[1], hdr_mem[2], hdr_mem[3]};
        r.image_height     = {hdr_mem[4], hdr_mem[5], hdr_mem[6], hdr_mem[7]};
        r.sample_depth     = hdr_mem[8];
        r.color_code       = hdr_mem[9];
        r.compression_kind = hdr_mem[10];
        r.filter_kind      = hdr_mem[11];
        r.interlace_kind   = hdr_mem[12];
        r.channel_count    = channels_for(hdr_mem[9]);
      end
      expected_reports.push_back(r);
    end
  endtask

  // ---------------------------------------------------------------------------
  // stimulus construction
  // ---------------------------------------------------------------------------

  // mostly short gaps, now and then a long one; none at all in calm stretches
  function automatic int unsigned pick_gap(input bit calm);
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // bias toward the all-zero and all-one byte
  function automatic logic [7:0] pick_byte();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'hFF;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [DATA_LEN_W-1:0] pick_wide_length();
    logic [31:0] r;
    r = $urandom();
    return r[DATA_LEN_W-1:0];
  endfunction

  // the length port only matters on a start byte; elsewhere it carries noise
  task automatic push_byte(input logic [7:0] b, input logic start,
                           input logic [DATA_LEN_W-1:0] len, input bit counts);
    chunk_byte_t item;
    item.value  = b;
    item.start  = start;
    item.length = start ? len : pick_wide_length();
    pending_bytes.push_back(item);
    if (counts) planned_bytes++;
  endtask

  // type bytes, chunk_body as data, then the big-endian crc (optionally corrupted)
  task automatic send_chunk(input logic [31:0] tw, input bit bad_crc);
    logic [31:0]           crc;
    logic [31:0]           body_len;
    logic [7:0]            b;
    crc      = CRC_INIT;
    body_len = chunk_body.size();
    for (int i = 0; i < 4; i++) begin
      b   = tw[31 - 8 * i -: 8];
      crc = crc32_step(crc, b);
      push_byte(b, i == 0, body_len[DATA_LEN_W-1:0], 1'b1);
    end
    foreach (chunk_body[i]) begin
      crc = crc32_step(crc, chunk_body[i]);
      push_byte(chunk_body[i], 1'b0, '0, 1'b1);
    end
    crc = crc ^ CRC_INIT;
    if (bad_crc) crc = crc ^ (32'h1 << $urandom_range(0, 31));
    for (int i = 0; i < 4; i++) push_byte(crc[31 - 8 * i -: 8], 1'b0, '0, 1'b1);
    stream_open = 1'b0;
  endtask

  // a chunk that starts but is cut off by the next start
  task automatic send_broken();
    logic [DATA_LEN_W-1:0] len;
    int unsigned           cap;
    int unsigned           n;
    len = $urandom_range(0, 1) ? pick_wide_length() : DATA_LEN_W'($urandom_range(0, 20));
    // stay short of the last crc byte so no report is owed
    cap = (len > 6) ? 12 : int'(len) + 6;
    if (cap > 12) cap = 12;
    n = $urandom_range(0, cap);
    push_byte(pick_byte(), 1'b1, len, 1'b1);
    repeat (n) push_byte(pick_byte(), 1'b0, '0, 1'b1);
    stream_open = 1'b1;
  endtask

  function automatic logic [7:0] pick_color();
    case ($urandom_range(0, 7))
      0: return COLOR_GRAY;
      1: return COLOR_RGB;
      2: return COLOR_PALETTE;
      3: return COLOR_GRAY_ALPHA;
      4: return COLOR_RGBA;
      5: return 8'd1;
      6: return 8'd5;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [31:0] known_type(input int unsigned n);
    case (n)
      0: return TYPE_IHDR;
      1: return TYPE_PLTE;
      2: return TYPE_IDAT;
      3: return TYPE_IEND;
      4: return TYPE_BKGD;
      default: return TYPE_CHRM;
    endcase
  endfunction

  // complete chunk of a random kind, lengths mostly legal for that kind, crc now and then corrupted
  task automatic send_random_chunk();
    int unsigned sel;
    int unsigned len;
    logic [31:0] tw;
    sel = $urandom_range(0, 7);
    if (sel < 6) tw = known_type(sel);
    else if (sel == 6) tw = $urandom();
    else tw = known_type($urandom_range(0, 5)) ^ (32'h1 << $urandom_range(0, 31));
    case (kind_for_type(tw))
      KIND_IHDR: len = ($urandom_range(0, 99) < 85) ? HEADER_LEN : $urandom_range(0, 20);
      KIND_PLTE: len = ($urandom_range(0, 99) < 70) ? 3 * $urandom_range(0, 6)
                                                    : $urandom_range(0, 20);
      KIND_IDAT: len = $urandom_range(0, 24);
      KIND_IEND: len = ($urandom_range(0, 99) < 80) ? 0 : $urandom_range(1, 5);
      KIND_BKGD: begin
        case ($urandom_range(0, 4))
          0, 1:    len = 1;
          2, 3:    len = 6;
          default: len = $urandom_range(0, 10);
        endcase
      end
      KIND_CHRM: len = ($urandom_range(0, 99) < 80) ? CHRM_LEN : $urandom_range(0, 40);
      default:   len = $urandom_range(0, 16);
    endcase
    chunk_body.delete();
    repeat (len) chunk_body.push_back(pick_byte());
    if (kind_for_type(tw) == KIND_IHDR && len == HEADER_LEN) begin
      chunk_body[9] = pick_color();
      // methods mostly zero as real files have them
      for (int i = 10; i < HEADER_LEN; i++)
        if ($urandom_range(0, 2) != 0) chunk_body[i] = 8'h00;
    end
    send_chunk(tw, $urandom_range(0, 99) < 15);
  endtask

  // ---------------------------------------------------------------------------
  // driver: one byte per transfer, prediction on every accepted byte
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : drive_bytes
    chunk_byte_t item;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        track_byte(data_byte, first_byte, data_length);
        accepted_bytes++;
      end
      // free to present a new byte when nothing waits or the held one just went
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_bytes.size() > 0) begin
          item = pending_bytes.pop_front();
          data_byte   <= item.value;
          first_byte  <= item.start;
          data_length <= item.length;
          in_valid    <= 1'b1;
          if ($urandom_range(0, 199) == 0) calm_in = !calm_in;
          send_gap = pick_gap(calm_in);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: compare each report with the oldest owed one
  // ---------------------------------------------------------------------------
  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : watch_reports
    result_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_reports.size() == 0) begin
          $error("report with no chunk owed: chunk_kind %0d", chunk_kind);
          mismatches++;
        end else begin
          want = expected_reports.pop_front();
          compare_field("chunk_kind",       32'(want.chunk_kind),       32'(chunk_kind));
          compare_field("crc_ok",           32'(want.crc_ok),           32'(crc_ok));
          compare_field("length_ok",        32'(want.length_ok),        32'(length_ok));
          compare_field("image_width",      want.image_width,           image_width);
          compare_field("image_height",     want.image_height,          image_height);
          compare_field("sample_depth",     32'(want.sample_depth),     32'(sample_depth));
          compare_field("color_code",       32'(want.color_code),       32'(color_code));
          compare_field("compression_kind", 32'(want.compression_kind), 32'(compression_kind));
          compare_field("filter_kind",      32'(want.filter_kind),      32'(filter_kind));
          compare_field("interlace_kind",   32'(want.interlace_kind),   32'(interlace_kind));
          compare_field("channel_count",    32'(want.channel_count),    32'(channel_count));
        end
      end
      // random back-pressure so both result buffer entries fill up at times
      if (recv_gap > 0) begin
        recv_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if ($urandom_range(0, 199) == 0) calm_out = !calm_out;
        recv_gap = pick_gap(calm_out);
      end
    end
  end

  // hang guard
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // sequence: build the byte stream, release reset, drain, report
  // ---------------------------------------------------------------------------
  initial begin : run_sequence
    int unsigned pick;

    // stray bytes before any start are dropped
    push_byte(8'h00, 1'b0, '0, 1'b0);
    push_byte(8'hFF, 1'b0, '0, 1'b0);
    // start with the largest length, then a restart abandons it
    push_byte(8'hFF, 1'b1, {DATA_LEN_W{1'b1}}, 1'b1);
    push_byte(8'h00, 1'b0, '0, 1'b1);
    // empty iend with a good crc
    chunk_body.delete();
    send_chunk(TYPE_IEND, 1'b0);
    // ihdr of wrong length: length check fails and header fields stay zero
    chunk_body.delete();
    chunk_body.push_back(8'hA5);
    send_chunk(TYPE_IHDR, 1'b1);

    // random part: mostly complete chunks, some cut off, some noise between chunks
    while (planned_bytes < BYTE_TARGET) begin
      pick = $urandom_range(0, 99);
      if (pick < 6) begin
        if (!stream_open) repeat ($urandom_range(1, 4)) push_byte(pick_byte(), 1'b0, '0, 1'b0);
      end else if (pick < 14) begin
        send_broken();
      end else begin
        send_random_chunk();
      end
    end
    total_bytes = pending_bytes.size();

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    while (accepted_bytes < total_bytes) @(posedge clk);
    while (expected_reports.size() != 0) @(posedge clk);
    // a report shows in the cycle after the last crc byte; leave room for strays
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

[filelist.f]
hdl/pcc_pkg.sv
hdl/pcc_out_buffer.sv
hdl/png_chunk_crc_checker_unit.sv
bench/png_chunk_crc_checker_unit_test.sv
